// ----- sv/lom_pkg.sv -----
`timescale 1ns / 1ps
package lom_pkg;
	localparam int BOOK_DEPTH = 32;
	localparam int PRICE_BITS = 20;
	localparam int QTY_BITS = 24;
	localparam int ID_BITS = 32;
	localparam int CNT_BITS = $clog2(BOOK_DEPTH + 1);
	localparam int IN_BITS = ID_BITS + PRICE_BITS + QTY_BITS;
	localparam int IN_BYTES = (IN_BITS + 7) / 8;
	localparam int OUT_BITS = 2 + 2 * ID_BITS + PRICE_BITS + QTY_BITS;
	localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

	typedef enum logic [1:0] {
		KIND_FILL = 2'd0,
		KIND_RESTED = 2'd1,
		KIND_DONE = 2'd2,
		KIND_REJECT = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MATCH,
		ST_FINAL,
		ST_SETTLE
	} state_t;

	// One resting order.
	typedef struct packed {
		logic vld;
		logic [ID_BITS-1:0] id;
		logic [PRICE_BITS-1:0] price;
		logic [QTY_BITS-1:0] qty;
	} entry_t;

	// Book command broadcast from the controller to every cell.
	typedef struct packed {
		logic ins;
		logic pop;
		logic dec;
		logic is_bid;
		entry_t item;
		logic [QTY_BITS-1:0] dec_qty;
	} book_cmd_t;
endpackage

// ----- sv/lom_cell.sv -----
`timescale 1ns / 1ps
module lom_cell (
	input logic clk,
	input logic arst_n,
	input lom_pkg::book_cmd_t cmd,
	input lom_pkg::entry_t prev_e,
	input lom_pkg::entry_t next_e,
	input logic prev_goes,
	output logic goes,
	output lom_pkg::entry_t e
);
	import lom_pkg::*;

	logic vld_q;
	logic [ID_BITS-1:0] id_q;
	logic [PRICE_BITS-1:0] price_q;
	logic [QTY_BITS-1:0] qty_q;
	logic better;

	// The new order belongs ahead of this entry when strictly better priced.
	always_comb begin
		better = cmd.is_bid ? (cmd.item.price > price_q) : (cmd.item.price < price_q);
		goes = !vld_q || better;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (cmd.pop) begin
			vld_q <= next_e.vld;
		end else if (cmd.ins && goes) begin
			vld_q <= prev_goes ? prev_e.vld : 1'b1;
		end
	end

	// Payload shifts up on pop, down behind the insertion point on insert.
	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			id_q <= next_e.id;
			price_q <= next_e.price;
			qty_q <= next_e.qty;
		end else if (cmd.ins && goes) begin
			if (prev_goes) begin
				id_q <= prev_e.id;
				price_q <= prev_e.price;
				qty_q <= prev_e.qty;
			end else begin
				id_q <= cmd.item.id;
				price_q <= cmd.item.price;
				qty_q <= cmd.item.qty;
			end
		end else if (cmd.dec && !prev_e.vld) begin
			qty_q <= qty_q - cmd.dec_qty;
		end
	end

	assign e = '{vld: vld_q, id: id_q, price: price_q, qty: qty_q};
endmodule

// ----- sv/lom_book.sv -----
`timescale 1ns / 1ps
module lom_book (
	input logic clk,
	input logic arst_n,
	input lom_pkg::book_cmd_t cmd,
	output lom_pkg::entry_t head,
	output logic full
);
	import lom_pkg::*;

	entry_t ent [BOOK_DEPTH];
	entry_t prv [BOOK_DEPTH];
	entry_t nxt [BOOK_DEPTH];
	logic gs [BOOK_DEPTH];
	logic pg [BOOK_DEPTH];

	// Row of cells; cell 0 holds the best order.
	for (genvar i = 0; i < BOOK_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign prv[i] = '0;
			assign pg[i] = 1'b0;
		end else begin : g_rest
			assign prv[i] = ent[i-1];
			assign pg[i] = gs[i-1];
		end
		if (i == BOOK_DEPTH - 1) begin : g_last
			assign nxt[i] = '0;
		end else begin : g_mid
			assign nxt[i] = ent[i+1];
		end
		lom_cell u_cell (
			.clk(clk), .arst_n(arst_n), .cmd(cmd), .prev_e(prv[i]), .next_e(nxt[i]),
			.prev_goes(pg[i]), .goes(gs[i]), .e(ent[i])
		);
	end

	assign head = ent[0];
	assign full = ent[BOOK_DEPTH-1].vld;
endmodule

// ----- sv/limit_order_matcher.sv -----
`timescale 1ns / 1ps
// Channel | Dir | Handshake      | Beat
// s_axis  | in  | tvalid/tready  | tdata: order_id, limit_price, quantity; tuser: side
// m_axis  | out | tvalid/tready  | tdata: kind, taker_id, maker_id, trade_price, trade_qty;
//         |     |                | tlast: last
// An order is taken in the idle state. Each fill is issued from the match state and
// followed by the settle state; once the order is filled, BOOK_DEPTH fills were
// issued or nothing more crosses, the final state issues the final result. Fills come one
// at a time from the head cell of the opposite book. Reset clears all valid bits at once.
// A stalled output holds the controller in place; the next order is taken only when idle.
module limit_order_matcher (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// order_id, limit_price, quantity, zero pad
	input logic [lom_pkg::IN_BYTES*8-1:0] s_axis_tdata,
	// side
	input logic s_axis_tuser,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// kind, taker_id, maker_id, trade_price, trade_qty, zero pad
	output logic [lom_pkg::OUT_BYTES*8-1:0] m_axis_tdata,
	output logic m_axis_tlast
);
	import lom_pkg::*;

	state_t state_q, state_d;
	logic sell_q;
	logic [ID_BITS-1:0] id_q;
	logic [PRICE_BITS-1:0] price_q;
	logic [QTY_BITS-1:0] qty_q, qty_d;
	logic [CNT_BITS-1:0] fills_q, fills_d;
	logic ov_q, ov_d;
	logic [OUT_BITS-1:0] od_q, od_d;
	logic ol_q, ol_d;
	book_cmd_t bcmd, acmd;
	entry_t bhead, ahead, opp;
	logic bfull, afull, crosses, can_emit;
	logic [QTY_BITS-1:0] m;
	kind_t fkind;

	lom_book u_bid (.clk(clk), .arst_n(arst_n), .cmd(bcmd), .head(bhead), .full(bfull));
	lom_book u_ask (.clk(clk), .arst_n(arst_n), .cmd(acmd), .head(ahead), .full(afull));

	assign s_axis_tready = (state_q == ST_IDLE);
	assign can_emit = !ov_q || m_axis_tready;

	// Match control.
	always_comb begin
		opp = sell_q ? bhead : ahead;
		crosses = opp.vld && (sell_q ? (price_q <= opp.price) : (price_q >= opp.price));
		m = (qty_q < opp.qty) ? qty_q : opp.qty;
		state_d = state_q;
		qty_d = qty_q;
		fills_d = fills_q;
		ov_d = ov_q && !m_axis_tready;
		od_d = od_q;
		ol_d = ol_q;
		fkind = KIND_DONE;
		bcmd = '0;
		acmd = '0;
		bcmd.is_bid = 1'b1;
		bcmd.item = '{vld: 1'b1, id: id_q, price: price_q, qty: qty_q};
		acmd.item = bcmd.item;
		case (state_q)
			ST_IDLE: begin
				fills_d = '0;
				if (s_axis_tvalid) begin
					state_d = ST_MATCH;
				end
			end
			ST_MATCH: begin
				if (can_emit) begin
					if (qty_q != '0 && fills_q < CNT_BITS'(BOOK_DEPTH) && crosses) begin
						ov_d = 1'b1;
						ol_d = 1'b0;
						od_d = {KIND_FILL, id_q, opp.id, opp.price, m};
						qty_d = qty_q - m;
						fills_d = fills_q + 1'b1;
						if (m == opp.qty) begin
							bcmd.pop = sell_q;
							acmd.pop = !sell_q;
						end else begin
							bcmd.dec = sell_q;
							acmd.dec = !sell_q;
							bcmd.dec_qty = m;
							acmd.dec_qty = m;
						end
						state_d = ST_SETTLE;
					end else begin
						state_d = ST_FINAL;
					end
				end
			end
			ST_SETTLE: begin
				state_d = ST_MATCH;
			end
			ST_FINAL: begin
				if (can_emit) begin
					if (qty_q == '0) begin
						fkind = KIND_DONE;
					end else if (sell_q ? afull : bfull) begin
						fkind = KIND_REJECT;
					end else begin
						fkind = KIND_RESTED;
						bcmd.ins = !sell_q;
						acmd.ins = sell_q;
					end
					ov_d = 1'b1;
					ol_d = 1'b1;
					od_d = {fkind, id_q, {ID_BITS{1'b0}}, price_q, qty_q};
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ov_q <= 1'b0;
			fills_q <= '0;
		end else begin
			state_q <= state_d;
			ov_q <= ov_d;
			fills_q <= fills_d;
		end
	end

	// Order latch and output register.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_axis_tvalid) begin
			sell_q <= s_axis_tuser;
			id_q <= s_axis_tdata[ID_BITS-1:0];
			price_q <= s_axis_tdata[ID_BITS+PRICE_BITS-1:ID_BITS];
			qty_q <= s_axis_tdata[IN_BITS-1:ID_BITS+PRICE_BITS];
		end else begin
			qty_q <= qty_d;
		end
		od_q <= od_d;
		ol_q <= ol_d;
	end

	// Field order is reversed in the concatenation above; repack lowest-first.
	assign m_axis_tvalid = ov_q;
	assign m_axis_tlast = ol_q;
	assign m_axis_tdata = {{(OUT_BYTES*8-OUT_BITS){1'b0}},
		od_q[QTY_BITS-1:0],
		od_q[PRICE_BITS+QTY_BITS-1:QTY_BITS],
		od_q[ID_BITS+PRICE_BITS+QTY_BITS-1:PRICE_BITS+QTY_BITS],
		od_q[2*ID_BITS+PRICE_BITS+QTY_BITS-1:ID_BITS+PRICE_BITS+QTY_BITS],
		od_q[OUT_BITS-1:OUT_BITS-2]};

`ifndef SYNTHESIS
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_axis_tready) else $error("ready while busy");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata)) else $error("beat changed");
	a_fill_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[1:0] == KIND_FILL) |-> !m_axis_tlast)
		else $error("fill marked last");
`endif
endmodule
